[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with reset disable
`define TCW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("text console check failed");

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  `TCW_ASSERT(lbl, clk, rst_n, (pre) |=> (post))

`endif

[hw/rtl/tcw_pkg.sv]
// package: sizes, codes, types and helpers of the text console writer
`default_nettype none

package tcw_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = 2000;

  // derived sizes
  localparam int ADDR_W  = $clog2(CELL_COUNT);
  localparam int SRC_W   = $clog2(CELL_COUNT + COLUMNS);
  localparam int PASS_W  = $clog2(ROWS + 1);
  localparam int POS_RAW = 13 + $clog2(COLUMNS + 1);
  localparam int POS_W   = (POS_RAW > 17) ? POS_RAW : 17;

  // one scroll pass: copy region and total sweep length
  localparam int LINES_END  = (ROWS - 1) * COLUMNS;
  localparam int BOTTOM_END = ROWS * COLUMNS;
  localparam int COPY_END   = (LINES_END < CELL_COUNT) ? LINES_END : CELL_COUNT;
  localparam int SCROLL_END = (BOTTOM_END < CELL_COUNT) ? BOTTOM_END : CELL_COUNT;

  // cursor bounds
  localparam logic signed [11:0] CUR_MAX = 12'sd2047;
  localparam logic signed [11:0] CUR_MIN = -12'sd2048;

  // control characters
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic signed [12:0] TAB_STEP = 13'sd4;

  typedef logic signed [11:0] cursor_t;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_SET  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_DRAIN
  } state_e;

  // outcome of one put character request
  typedef struct packed {
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [15:0]       mem_data;
    cursor_t           col;
    cursor_t           row;
    logic              scroll;
    logic [PASS_W-1:0] passes;
  } put_plan_t;

  // clamp a 13-bit signed value to the cursor range
  function automatic cursor_t sat12(logic signed [12:0] s);
    cursor_t r;
    if (s > 13'sd2047) begin
      r = CUR_MAX;
    end else if (s < -13'sd2048) begin
      r = CUR_MIN;
    end else begin
      r = s[11:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tcw_cells.sv]
// screen cell memory: one write port, one registered read port
`default_nettype none

module tcw_cells (
  input  wire logic                      clk_i,
  input  wire logic                      wr_en_i,
  input  wire logic [tcw_pkg::ADDR_W-1:0] wr_addr_i,
  input  wire logic [15:0]               wr_data_i,
  input  wire logic [tcw_pkg::ADDR_W-1:0] rd_addr_i,
  output logic      [15:0]               rd_data_o
);

  logic [15:0] mem [tcw_pkg::CELL_COUNT];
  logic [15:0] rd_data_q;

  // write, and read old data on the same edge
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[hw/rtl/tcw_cursor.sv]
// put character decode: position, cell write, cursor update, scroll count
`default_nettype none

module tcw_cursor (
  input  wire tcw_pkg::cursor_t   col_i,
  input  wire tcw_pkg::cursor_t   row_i,
  input  wire logic [7:0]         style_i,
  input  wire logic [7:0]         char_code_i,
  output tcw_pkg::put_plan_t      plan_o
);

  logic signed [tcw_pkg::POS_W-1:0] row_ext;
  logic signed [tcw_pkg::POS_W-1:0] col_ext;
  logic signed [tcw_pkg::POS_W-1:0] pos;
  logic signed [12:0]               col13;
  logic signed [12:0]               row13;
  logic                             pos_neg;
  logic                             pos_in;
  tcw_pkg::cursor_t                 col_n;
  tcw_pkg::cursor_t                 row_n;
  logic                             we;
  logic [11:0]                      over;

  // linear position, row times columns plus column
  assign row_ext = {{(tcw_pkg::POS_W-12){row_i[11]}}, row_i};
  assign col_ext = {{(tcw_pkg::POS_W-12){col_i[11]}}, col_i};
  assign pos     = row_ext * $signed(tcw_pkg::POS_W'(tcw_pkg::COLUMNS)) + col_ext;
  assign pos_neg = pos[tcw_pkg::POS_W-1];
  assign pos_in  = !pos_neg && (pos < $signed(tcw_pkg::POS_W'(tcw_pkg::CELL_COUNT)));

  assign col13 = {col_i[11], col_i};
  assign row13 = {row_i[11], row_i};

  // cursor movement per character
  always_comb begin
    col_n = col_i;
    row_n = row_i;
    we    = 1'b0;
    if (!pos_neg) begin
      case (char_code_i)
        tcw_pkg::CH_BS:  col_n = tcw_pkg::sat12(col13 - 13'sd1);
        tcw_pkg::CH_TAB: col_n = tcw_pkg::sat12(col13 + tcw_pkg::TAB_STEP);
        tcw_pkg::CH_NL:  row_n = tcw_pkg::sat12(row13 + 13'sd1);
        tcw_pkg::CH_CR:  col_n = '0;
        default: begin
          we    = pos_in;
          col_n = tcw_pkg::sat12(col13 + 13'sd1);
        end
      endcase
    end
  end

  // scroll passes, capped at the screen height
  assign over = 12'(row_n) - 12'(tcw_pkg::ROWS - 1);

  // a negative position leaves the row alone, no scroll either
  always_comb begin
    plan_o          = '0;
    plan_o.mem_we   = we;
    plan_o.mem_addr = pos[tcw_pkg::ADDR_W-1:0];
    plan_o.mem_data = {style_i, char_code_i};
    plan_o.col      = col_n;
    plan_o.row      = row_n;
    if (!pos_neg && (row_n >= 12'sd0 + tcw_pkg::cursor_t'(tcw_pkg::ROWS))) begin
      plan_o.scroll = 1'b1;
      plan_o.row    = tcw_pkg::cursor_t'(tcw_pkg::ROWS - 1);
      plan_o.passes = (over > 12'(tcw_pkg::ROWS)) ?
                      tcw_pkg::PASS_W'(tcw_pkg::ROWS) : over[tcw_pkg::PASS_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/text_console_writer.sv]
// top level: request sequencer, scroll engine and cursor registers
`default_nettype none

// Text console writer. A request is taken when start is high and busy is low;
// its result shows on the result ports for one cycle, marked by done_o, in
// the cycle after the request (or after its scroll finishes) and cannot be
// held off. Set cursor, read cell and put character without scrolling leave
// busy low and can follow one another every cycle. A put character that
// scrolls keeps busy high through up to ROWS passes, each a sweep over
// min(ROWS*COLUMNS, CELL_COUNT) cells, and a final drain state, because
// every cell of a pass goes through the single read and write port of the
// cell memory. After reset the memory is cleared one cell per cycle, so busy
// stays high until all CELL_COUNT (2000) cells have been cleared.
module text_console_writer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [7:0]         style_i,
  input  wire logic [7:0]         char_code_i,
  input  wire logic signed [11:0] new_column_i,
  input  wire logic signed [11:0] new_row_i,
  input  wire logic [10:0]        cell_index_i,
  output logic                    done_o,
  output logic signed [11:0]      cursor_column_o,
  output logic signed [11:0]      cursor_row_o,
  output logic [15:0]             cell_data_o
);

  localparam logic [tcw_pkg::ADDR_W-1:0] CLEAR_LAST  = tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] SCROLL_LAST = tcw_pkg::ADDR_W'(tcw_pkg::SCROLL_END - 1);

  tcw_pkg::state_e           state_q, state_d;
  logic [tcw_pkg::ADDR_W-1:0] clr_q, clr_d;
  logic [tcw_pkg::ADDR_W-1:0] dst_q, dst_d;
  logic [tcw_pkg::PASS_W-1:0] pass_q, pass_d;
  logic                       pend_q, pend_d;
  logic [tcw_pkg::ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic                       pend_src_q, pend_src_d;
  logic                       done_q, done_d;
  logic                       rd_sel_q, rd_sel_d;
  tcw_pkg::cursor_t           col_q, col_d;
  tcw_pkg::cursor_t           row_q, row_d;
  logic                       fwd_q;
  logic [15:0]                fwd_data_q;

  logic                       accept;
  logic                       wr_en;
  logic [tcw_pkg::ADDR_W-1:0] wr_addr;
  logic [15:0]                wr_data;
  logic [tcw_pkg::ADDR_W-1:0] rd_addr;
  logic [15:0]                mem_rdata;
  logic [15:0]                rdata;
  logic [15:0]                idx_wide;
  logic                       idx_ok;
  logic [tcw_pkg::SRC_W-1:0]  src;
  logic                       src_ok;
  tcw_pkg::put_plan_t         plan;

  tcw_cells u_cells (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (mem_rdata)
  );

  tcw_cursor u_cursor (
    .col_i       (col_q),
    .row_i       (row_q),
    .style_i     (style_i),
    .char_code_i (char_code_i),
    .plan_o      (plan)
  );

  assign accept = start && (state_q == tcw_pkg::ST_IDLE);
  assign busy   = (state_q != tcw_pkg::ST_IDLE);

  // read cell range check
  assign idx_wide = 16'(cell_index_i);
  assign idx_ok   = idx_wide < 16'(tcw_pkg::CELL_COUNT);

  // scroll source for the current destination
  assign src    = tcw_pkg::SRC_W'(dst_q) + tcw_pkg::SRC_W'(tcw_pkg::COLUMNS);
  assign src_ok = (tcw_pkg::SRC_W'(dst_q) < tcw_pkg::SRC_W'(tcw_pkg::COPY_END)) &&
                  (src < tcw_pkg::SRC_W'(tcw_pkg::CELL_COUNT));

  // forward a write that lands on the address read in the same cycle
  assign rdata = fwd_q ? fwd_data_q : mem_rdata;

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    dst_d       = dst_q;
    pass_d      = pass_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    pend_src_d  = pend_src_q;
    done_d      = 1'b0;
    rd_sel_d    = 1'b0;
    col_d       = col_q;
    row_d       = row_q;
    rd_addr     = idx_wide[tcw_pkg::ADDR_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = pend_addr_q;
    wr_data     = '0;
    case (state_q)
      tcw_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + tcw_pkg::ADDR_W'(1);
        if (clr_q == CLEAR_LAST) begin
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          case (opcode_i)
            tcw_pkg::OP_PUT: begin
              col_d   = plan.col;
              row_d   = plan.row;
              wr_en   = plan.mem_we;
              wr_addr = plan.mem_addr;
              wr_data = plan.mem_data;
              if (plan.scroll) begin
                done_d  = 1'b0;
                dst_d   = '0;
                pass_d  = plan.passes;
                state_d = tcw_pkg::ST_SCROLL;
              end
            end
            tcw_pkg::OP_SET: begin
              col_d = new_column_i;
              row_d = new_row_i;
            end
            tcw_pkg::OP_READ: begin
              rd_sel_d = idx_ok;
            end
            default: begin
            end
          endcase
        end
      end
      tcw_pkg::ST_SCROLL: begin
        // write back the cell fetched last cycle, fetch the next one
        wr_en       = pend_q;
        wr_data     = pend_src_q ? rdata : 16'h0000;
        rd_addr     = src[tcw_pkg::ADDR_W-1:0];
        pend_d      = 1'b1;
        pend_addr_d = dst_q;
        pend_src_d  = src_ok;
        dst_d       = dst_q + tcw_pkg::ADDR_W'(1);
        if (dst_q == SCROLL_LAST) begin
          dst_d  = '0;
          pass_d = pass_q - tcw_pkg::PASS_W'(1);
          if (pass_q == tcw_pkg::PASS_W'(1)) begin
            state_d = tcw_pkg::ST_DRAIN;
          end
        end
      end
      tcw_pkg::ST_DRAIN: begin
        wr_en   = pend_q;
        wr_data = pend_src_q ? rdata : 16'h0000;
        done_d  = 1'b1;
        state_d = tcw_pkg::ST_IDLE;
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tcw_pkg::ST_CLEAR;
      clr_q    <= '0;
      dst_q    <= '0;
      pass_q   <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
      rd_sel_q <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      fwd_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      dst_q    <= dst_d;
      pass_q   <= pass_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
      rd_sel_q <= rd_sel_d;
      col_q    <= col_d;
      row_q    <= row_d;
      fwd_q    <= wr_en && (wr_addr == rd_addr);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    pend_src_q  <= pend_src_d;
    fwd_data_q  <= wr_data;
  end

  assign done_o          = done_q;
  assign cursor_column_o = col_q;
  assign cursor_row_o    = row_q;
  assign cell_data_o     = rd_sel_q ? rdata : 16'h0000;

endmodule

`default_nettype wire

[hw/rtl/tcw_checker.sv]
// port-level checker for the text console writer, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module tcw_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic [1:0]         opcode_i,
  input wire logic signed [11:0] new_column_i,
  input wire logic signed [11:0] new_row_i,
  input wire logic               done_o,
  input wire logic signed [11:0] cursor_column_o,
  input wire logic signed [11:0] cursor_row_o,
  input wire logic [15:0]        cell_data_o
);

  logic take;
  assign take = start && !busy;

  // a result follows a taken request or the end of busy work
  `TCW_ASSERT(a_done_cause, clk_i, rst_ni, done_o |-> ($past(take) || $past(busy)))
  // results only appear while requests can be taken
  `TCW_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy)
  // requests other than put character answer in the next cycle
  `TCW_ASSERT_NEXT(a_quick, clk_i, rst_ni, take && (opcode_i != tcw_pkg::OP_PUT), done_o)
  // set cursor reports the loaded position
  `TCW_ASSERT_NEXT(a_set_cursor, clk_i, rst_ni, take && (opcode_i == tcw_pkg::OP_SET), (cursor_column_o == $past(new_column_i)) && (cursor_row_o == $past(new_row_i)))
  // cell data is zero outside a result
  `TCW_ASSERT(a_data_quiet, clk_i, rst_ni, !done_o |-> (cell_data_o == 16'h0000))

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

`default_nettype wire
